FILE: sv/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, register indexes and controller/datapath command types for
// the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    // semi-axis width, coordinate widths and the widths that follow from them
    localparam int RADIUS_BITS = 10;
    localparam int COORD_W     = 11;
    localparam int OUT_W       = 13;
    localparam int X_W         = RADIUS_BITS + 1;
    localparam int Y_W         = RADIUS_BITS + 2;
    localparam int R2_W        = 2 * RADIUS_BITS;
    localparam int SQ_W        = 2 * RADIUS_BITS + 4;
    localparam int OP_W        = 2 * RADIUS_BITS + 5;
    localparam int DEC_W       = 4 * RADIUS_BITS + 8;
    localparam int POS_W       = OUT_W + RADIUS_BITS;
    localparam int CFG_W       = (COORD_W > RADIUS_BITS) ? COORD_W : RADIUS_BITS;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS_X = 2'd2,
        CFG_RADIUS_Y = 2'd3
    } t_cfg_idx;

    // operand pairs for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_X_RY2,
        MUL_Y_RX2,
        MUL_TX_TX,
        MUL_TY_TY,
        MUL_SQ_RY2,
        MUL_SQ_RX2,
        MUL_RX2_RY2
    } t_mul_sel;

    // datapath register operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_RX2,
        OP_LD_RY2,
        OP_RELOAD,
        OP_DEC_SUB,
        OP_LD_T,
        OP_LD_SQ,
        OP_T_ADD4,
        OP_T_SUB4,
        OP_SWITCH,
        OP_EMIT,
        OP_ADD_CONST,
        OP_ADD_XTERM,
        OP_SUB_YTERM
    } t_dp_op;

    typedef struct packed {
        t_mul_sel mul;
        t_dp_op   op;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic region_two;
        logic below;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/mer_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_in_if
// Step channel: valid/ready handshake carrying the restart flag.
// ----------------------------------------------------------------------------
interface mer_in_if import mer_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

FILE: sv/mer_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_out_if
// Point channel: valid/ready handshake carrying four mirrored coordinates.
// ----------------------------------------------------------------------------
interface mer_out_if import mer_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] x_plus;
    logic signed [OUT_W-1:0] x_minus;
    logic signed [OUT_W-1:0] y_plus;
    logic signed [OUT_W-1:0] y_minus;
    logic                    last;

    modport source (output valid, output x_plus, output x_minus, output y_plus,
                    output y_minus, output last, input ready);
    modport sink   (input valid, input x_plus, input x_minus, input y_plus,
                    input y_minus, input last, output ready);
endinterface

FILE: sv/mer_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath
// Configuration registers, shared multiplier, ellipse state, decision
// accumulator and the output register of the point channel.
// ----------------------------------------------------------------------------
module mer_datapath import mer_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [OUT_W-1:0] o_x_plus,
    output logic signed [OUT_W-1:0] o_x_minus,
    output logic signed [OUT_W-1:0] o_y_plus,
    output logic signed [OUT_W-1:0] o_y_minus,
    output logic                    o_last
);

    // configuration
    logic [COORD_W-1:0]     r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_rx, r_ry;

    // squared radii and ellipse state
    logic [R2_W-1:0]         r_rx2, r_ry2;
    logic [X_W-1:0]          r_x;
    logic signed [Y_W-1:0]   r_y;
    logic signed [DEC_W-1:0] r_dec;
    logic signed [DEC_W-1:0] r_t;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_r2;
    logic                    r_active;
    logic                    r_xterm, r_yterm;

    // multiplier
    logic signed [OP_W-1:0]   w_a, w_b;
    logic signed [2*OP_W-1:0] w_full;
    logic signed [DEC_W-1:0]  r_prod;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_xp, r_xm, r_yp, r_ym;
    logic                    r_last;

    // extended operands
    logic signed [OP_W-1:0]  e_rx, e_ry, e_rx2, e_ry2, e_x, e_y, e_tx, e_ty, e_sq;
    logic signed [Y_W:0]     w_ty;
    logic signed [DEC_W-1:0] w_rx2_d, w_ry2_d, w_const;
    logic signed [DEC_W-1:0] w_bias, w_d4q;
    logic signed [Y_W-1:0]   w_y_new;
    logic                    w_dec_step;
    logic signed [POS_W-1:0] w_cx, w_cy, w_xo, w_yo;
    logic signed [POS_W-1:0] w_xp, w_xm, w_yp, w_ym;
    logic                    w_out_free;

    // operand extension
    assign w_ty  = {r_y[Y_W-1], r_y} - (Y_W+1)'(1);
    assign e_rx  = {{(OP_W-RADIUS_BITS){1'b0}}, r_rx};
    assign e_ry  = {{(OP_W-RADIUS_BITS){1'b0}}, r_ry};
    assign e_rx2 = {{(OP_W-R2_W){1'b0}}, r_rx2};
    assign e_ry2 = {{(OP_W-R2_W){1'b0}}, r_ry2};
    assign e_x   = {{(OP_W-X_W){1'b0}}, r_x};
    assign e_y   = {{(OP_W-Y_W){r_y[Y_W-1]}}, r_y};
    assign e_tx  = {{(OP_W-X_W-1){1'b0}}, r_x, 1'b1};
    assign e_ty  = {{(OP_W-Y_W-1){w_ty[Y_W]}}, w_ty};
    assign e_sq  = {{(OP_W-SQ_W){1'b0}}, r_sq};

    // multiplier operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cmd.mul)
            MUL_NONE:    begin w_a = '0;    w_b = '0;    end
            MUL_RX_RX:   begin w_a = e_rx;  w_b = e_rx;  end
            MUL_RY_RY:   begin w_a = e_ry;  w_b = e_ry;  end
            MUL_RX2_RY:  begin w_a = e_rx2; w_b = e_ry;  end
            MUL_X_RY2:   begin w_a = e_x;   w_b = e_ry2; end
            MUL_Y_RX2:   begin w_a = e_y;   w_b = e_rx2; end
            MUL_TX_TX:   begin w_a = e_tx;  w_b = e_tx;  end
            MUL_TY_TY:   begin w_a = e_ty;  w_b = e_ty;  end
            MUL_SQ_RY2:  begin w_a = e_sq;  w_b = e_ry2; end
            MUL_SQ_RX2:  begin w_a = e_sq;  w_b = e_rx2; end
            MUL_RX2_RY2: begin w_a = e_rx2; w_b = e_ry2; end
            default:     begin w_a = '0;    w_b = '0;    end
        endcase
    end

    assign w_full = w_a * w_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[DEC_W-1:0];
    end

    // decision helpers
    assign w_rx2_d = {{(DEC_W-R2_W){1'b0}}, r_rx2};
    assign w_ry2_d = {{(DEC_W-R2_W){1'b0}}, r_ry2};
    assign w_const = r_r2 ? w_rx2_d : w_ry2_d;

    // region-2 start value, divided by four toward zero
    assign w_bias = r_t + (r_t[DEC_W-1] ? DEC_W'(3) : DEC_W'(0));
    assign w_d4q  = w_bias >>> 2;

    // step direction: region 1 steps y when decision is not negative
    assign w_dec_step = r_r2 ? (r_dec > 0) : ~r_dec[DEC_W-1];
    assign w_y_new    = (r_r2 || w_dec_step) ? (r_y - Y_W'(1)) : r_y;

    // mirrored coordinates
    assign w_cx = {{(POS_W-COORD_W){1'b0}}, r_cx};
    assign w_cy = {{(POS_W-COORD_W){1'b0}}, r_cy};
    assign w_xo = {{(POS_W-X_W){1'b0}}, r_x};
    assign w_yo = {{(POS_W-Y_W){r_y[Y_W-1]}}, r_y};
    assign w_xp = w_cx + w_xo;
    assign w_xm = w_cx - w_xo;
    assign w_yp = w_cy + w_yo;
    assign w_ym = w_cy - w_yo;

    assign w_out_free = ~r_out_valid | i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_rx <= '0;
            r_ry <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cx <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Y: r_cy <= i_cfg_data[COORD_W-1:0];
                CFG_RADIUS_X: r_rx <= i_cfg_data[RADIUS_BITS-1:0];
                CFG_RADIUS_Y: r_ry <= i_cfg_data[RADIUS_BITS-1:0];
            endcase
        end
    end

    // ellipse state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_r2     <= 1'b0;
            r_active <= 1'b0;
            r_xterm  <= 1'b0;
            r_yterm  <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LD_RX2: r_rx2 <= r_prod[R2_W-1:0];
                OP_LD_RY2: r_ry2 <= r_prod[R2_W-1:0];
                OP_RELOAD: begin
                    r_ry2    <= r_prod[R2_W-1:0];
                    r_x      <= '0;
                    r_y      <= {{(Y_W-RADIUS_BITS){1'b0}}, r_ry};
                    r_dec    <= {{(DEC_W-R2_W){1'b0}}, r_prod[R2_W-1:0]}
                                + (w_rx2_d >>> 2);
                    r_r2     <= 1'b0;
                    r_active <= 1'b1;
                end
                OP_DEC_SUB: r_dec <= r_dec - r_prod;
                OP_LD_T:    r_t   <= r_prod;
                OP_LD_SQ:   r_sq  <= r_prod[SQ_W-1:0];
                OP_T_ADD4:  r_t   <= r_t + (r_prod <<< 2);
                OP_T_SUB4:  r_t   <= r_t - (r_prod <<< 2);
                OP_SWITCH: begin
                    r_dec <= w_d4q;
                    r_r2  <= 1'b1;
                end
                OP_EMIT: begin
                    r_y      <= w_y_new;
                    r_active <= ~w_y_new[Y_W-1];
                    if (r_r2) begin
                        r_xterm <= ~w_dec_step;
                        r_yterm <= 1'b1;
                        if (!w_dec_step) begin
                            r_x <= r_x + X_W'(1);
                        end
                    end else begin
                        r_xterm <= 1'b1;
                        r_yterm <= w_dec_step;
                        r_x     <= r_x + X_W'(1);
                    end
                end
                OP_ADD_CONST: r_dec <= r_dec + w_const;
                OP_ADD_XTERM: begin
                    if (r_xterm) begin
                        r_dec <= r_dec + (r_prod <<< 1);
                    end
                end
                OP_SUB_YTERM: begin
                    if (r_yterm) begin
                        r_dec <= r_dec - (r_prod <<< 1);
                    end
                end
                default: ;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_xp   <= w_xp[OUT_W-1:0];
            r_xm   <= w_xm[OUT_W-1:0];
            r_yp   <= w_yp[OUT_W-1:0];
            r_ym   <= w_ym[OUT_W-1:0];
            r_last <= w_y_new[Y_W-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_plus    = r_xp;
    assign o_x_minus   = r_xm;
    assign o_y_plus    = r_yp;
    assign o_y_minus   = r_ym;
    assign o_last      = r_last;

    assign o_status.active     = r_active;
    assign o_status.region_two = r_r2;
    assign o_status.below      = r_t < r_prod;
    assign o_status.out_free   = w_out_free;

endmodule

FILE: sv/mer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Step sequencer: walks one loop iteration through the shared multiplier
// and issues datapath commands.
// ----------------------------------------------------------------------------
module mer_ctrl import mer_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_restart,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_LOAD,
        S_LOAD2,
        S_CMP1,
        S_CMP2,
        S_CMP3,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SW4,
        S_SW5,
        S_SW6,
        S_SW7,
        S_OUT,
        S_U1,
        S_U2,
        S_U3
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    logic   r_restart;

    // next state and command decode
    always_comb begin
        n_state   = r_state;
        o_cmd.mul = MUL_NONE;
        o_cmd.op  = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.mul = MUL_RX_RX;
                n_state   = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul = MUL_RY_RY;
                o_cmd.op  = OP_LD_RX2;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                if (r_restart) begin
                    o_cmd.op  = OP_RELOAD;
                    o_cmd.mul = MUL_RX2_RY;
                    n_state   = S_LOAD2;
                end else begin
                    o_cmd.op = OP_LD_RY2;
                    if (!i_status.active) begin
                        n_state = S_IDLE;
                    end else if (i_status.region_two) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CMP1;
                    end
                end
            end
            S_LOAD2: begin
                o_cmd.op = OP_DEC_SUB;
                n_state  = S_CMP1;
            end
            // region test: x*ry^2 against y*rx^2
            S_CMP1: begin
                o_cmd.mul = MUL_X_RY2;
                n_state   = S_CMP2;
            end
            S_CMP2: begin
                o_cmd.op  = OP_LD_T;
                o_cmd.mul = MUL_Y_RX2;
                n_state   = S_CMP3;
            end
            S_CMP3: begin
                n_state = i_status.below ? S_OUT : S_SW1;
            end
            // region-2 start value at four times scale
            S_SW1: begin
                o_cmd.mul = MUL_TX_TX;
                n_state   = S_SW2;
            end
            S_SW2: begin
                o_cmd.op  = OP_LD_SQ;
                o_cmd.mul = MUL_TY_TY;
                n_state   = S_SW3;
            end
            S_SW3: begin
                o_cmd.op  = OP_LD_SQ;
                o_cmd.mul = MUL_SQ_RY2;
                n_state   = S_SW4;
            end
            S_SW4: begin
                o_cmd.op  = OP_LD_T;
                o_cmd.mul = MUL_SQ_RX2;
                n_state   = S_SW5;
            end
            S_SW5: begin
                o_cmd.op  = OP_T_ADD4;
                o_cmd.mul = MUL_RX2_RY2;
                n_state   = S_SW6;
            end
            S_SW6: begin
                o_cmd.op = OP_T_SUB4;
                n_state  = S_SW7;
            end
            S_SW7: begin
                o_cmd.op = OP_SWITCH;
                n_state  = S_OUT;
            end
            // emit the point and step the offsets
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_U1;
                end
            end
            // decision update
            S_U1: begin
                o_cmd.op  = OP_ADD_CONST;
                o_cmd.mul = MUL_X_RY2;
                n_state   = S_U2;
            end
            S_U2: begin
                o_cmd.op  = OP_ADD_XTERM;
                o_cmd.mul = MUL_Y_RX2;
                n_state   = S_U3;
            end
            S_U3: begin
                o_cmd.op = OP_SUB_YTERM;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b1;
            r_restart <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
            if (r_ready && i_in_valid) begin
                r_restart <= i_in_restart;
            end
        end
    end

    assign o_in_ready = r_ready;

endmodule

FILE: sv/midpoint_ellipse_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer: one step beat in, at most one point beat out.
// ----------------------------------------------------------------------------
// Write center and radii through the configuration port, then send step
// beats; a beat with restart set reloads the ellipse before stepping. Each
// active step returns the current offset mirrored into four coordinates,
// wrapped to 13 bits, with last set on the final point set; steps after
// that return nothing until the next restart. All products go through one
// shared multiplier with a registered result. The point register lets the
// next step beat in while a point waits to be taken.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top import mer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mer_in_if.sink               i_in,
    mer_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    mer_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_restart (i_in.restart),
        .o_in_ready   (i_in.ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    // arithmetic and point register
    mer_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_x_plus    (o_out.x_plus),
        .o_x_minus   (o_out.x_minus),
        .o_y_plus    (o_out.y_plus),
        .o_y_minus   (o_out.y_minus),
        .o_last      (o_out.last)
    );

endmodule
